### rtl/qau_pkg.sv
// Shared constants for the quaternion arithmetic unit.
package qau_pkg;

    localparam int DEF_FRAC_BITS = 12;
    localparam int DEF_WORD_BITS = 16;

    localparam int ACT_W = 2;

    localparam logic [ACT_W-1:0] ACT_SUM  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_MUL  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_INV  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CONJ = 2'd3;

    // Bit positions inside the result sideband.
    localparam int FLAG_SAT = 0;
    localparam int FLAG_DZ  = 1;
    localparam int FLAG_W   = 2;

endpackage

### rtl/qau_div_step.sv
// One restoring-division step for the four lanes of the reciprocal path.
module qau_div_step
    import qau_pkg::*;
#(
    parameter int DW    = 40,
    parameter int NW    = 33,
    parameter int SHIFT = 0
) (
    input  logic [NW-1:0]         norm,
    input  logic [3:0][DW-1:0]    rem_in,
    output logic [3:0][DW-1:0]    rem_out,
    output logic [3:0]            ge
);

    localparam int CW = (DW > NW + SHIFT) ? DW : NW + SHIFT;

    logic [CW-1:0] dsor;
    logic [CW-1:0] rext [4];

    always_comb begin
        dsor = CW'(norm) << SHIFT;
        for (int k = 0; k < 4; k++) begin
            rext[k]    = CW'(rem_in[k]);
            ge[k]      = (rext[k] >= dsor);
            rem_out[k] = ge[k] ? DW'(rext[k] - dsor) : rem_in[k];
        end
    end

endmodule

### rtl/quaternion_arith_unit.sv
// Quaternion ALU: sum, Hamilton product, inverse and conjugate in Q-format fixed point.
// The restoring divider has an overflow-test stage plus one stage per quotient bit.
// Throughput is one word per cycle while the output is not stalled.
// Every word walks the same pipeline, so results leave in the order words came in.
// Reset (aresetn low, synchronous) clears all stage valid bits; payload is not reset.
module quaternion_arith_unit
    import qau_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int WORD_BITS = DEF_WORD_BITS,
    localparam int S_DW = ((8 * WORD_BITS + 7) / 8) * 8,
    localparam int M_DW = ((4 * WORD_BITS + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w from the lowest bit up, zero padded
    input  logic [S_DW-1:0]  s_axis_tdata,
    // action
    input  logic [ACT_W-1:0] s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // r_x, r_y, r_z, r_w from the lowest bit up, zero padded
    output logic [M_DW-1:0]  m_axis_tdata,
    // saturated, div_by_zero from the lowest bit up
    output logic [FLAG_W-1:0] m_axis_tuser
);

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * W;
    // Width that holds any sum of four shifted products, sums and negations.
    localparam int TW   = ((2 * W - F > W) ? 2 * W - F : W) + 2;
    localparam int NW   = 2 * W + 1;
    localparam int DW   = W + 2 * F;
    // Divider steps: one overflow test plus one per quotient bit.
    localparam int NDIV = W + 1;
    // Stages: operand products, term sums, NDIV divider steps, output register.
    localparam int NSTG = NDIV + 3;

    localparam logic signed [TW-1:0] TMAX = {{(TW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [TW-1:0] TMIN = {{(TW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic [W-1:0] LIM_P = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] LIM_N = {1'b1, {(W-1){1'b0}}};

    // Clip to the signed word range; the top bit of the result is the clip flag.
    function automatic logic [W:0] clip_word(input logic signed [TW-1:0] v);
        logic [W:0] r;
        if (v > TMAX) begin
            r = {1'b1, TMAX[W-1:0]};
        end else if (v < TMIN) begin
            r = {1'b1, TMIN[W-1:0]};
        end else begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Flow control: a stage moves when it is empty or its successor moves,
    // so bubbles collapse and a stalled output still lets words fill in.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] adv;

    always_comb begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || m_axis_tready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            adv[s] = !vld_reg[s] || adv[s+1];
        end
        vld_next = vld_reg;
        if (adv[0]) begin
            vld_next[0] = s_axis_tvalid;
        end
        for (int s = 1; s < NSTG; s++) begin
            if (adv[s]) begin
                vld_next[s] = vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_axis_tready = adv[0];

    // ------------------------------------------------------------------
    // Stage A: unpack operands and form all sixteen cross products plus
    // the four squares of a.
    // ------------------------------------------------------------------
    logic signed [W-1:0]  a_in [4];
    logic signed [W-1:0]  b_in [4];

    logic [ACT_W-1:0]     act_a_reg;
    logic signed [W-1:0]  a_a_reg [4];
    logic signed [W-1:0]  b_a_reg [4];
    logic signed [PW-1:0] prd_a_reg [4][4];
    logic signed [PW-1:0] sq_a_reg [4];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            a_in[k] = s_axis_tdata[k*W +: W];
            b_in[k] = s_axis_tdata[(k+4)*W +: W];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            act_a_reg <= s_axis_tuser;
            for (int i = 0; i < 4; i++) begin
                a_a_reg[i]  <= a_in[i];
                b_a_reg[i]  <= b_in[i];
                sq_a_reg[i] <= a_in[i] * a_in[i];
                for (int j = 0; j < 4; j++) begin
                    prd_a_reg[i][j] <= a_in[i] * b_in[j];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage B: shift products down, add the terms, clip, pick the result
    // of the non-inverse operations, and set up the reciprocal dividend.
    // Index 0 of the divider arrays is this stage's register.
    // ------------------------------------------------------------------
    logic [3:0][DW-1:0]  dv_rem_reg [NDIV+1];
    logic [3:0][W-1:0]   dv_q_reg   [NDIV+1];
    logic [3:0]          dv_ovf_reg [NDIV+1];
    logic [3:0]          dv_neg_reg [NDIV+1];
    logic [NW-1:0]       dv_n_reg   [NDIV+1];
    logic [3:0][W-1:0]   dv_res_reg [NDIV+1];
    logic                dv_sat_reg [NDIV+1];
    logic                dv_dz_reg  [NDIV+1];
    logic                dv_inv_reg [NDIV+1];

    logic signed [TW-1:0] trm [4][4];
    logic signed [TW-1:0] mul_v [4];
    logic signed [TW-1:0] sum_v [4];
    logic signed [TW-1:0] cnj_v [4];
    logic signed [TW-1:0] mag_v [4];
    logic [W:0]           mul_c [4];
    logic [W:0]           sum_c [4];
    logic [W:0]           cnj_c [4];
    logic [3:0][W-1:0]    res_b;
    logic                 sat_b;
    logic [3:0]           neg_b;
    logic [3:0][DW-1:0]   rem_b;
    logic [NW-1:0]        norm_b;
    logic                 zero_b;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                trm[i][j] = TW'(prd_a_reg[i][j] >>> F);
            end
        end
        // Component order is x, y, z, w.
        mul_v[0] = trm[3][0] + trm[0][3] + trm[1][2] - trm[2][1];
        mul_v[1] = trm[3][1] + trm[1][3] - trm[0][2] + trm[2][0];
        mul_v[2] = trm[3][2] + trm[2][3] + trm[0][1] - trm[1][0];
        mul_v[3] = trm[3][3] - trm[0][0] - trm[1][1] - trm[2][2];

        norm_b = '0;
        zero_b = 1'b1;
        for (int k = 0; k < 4; k++) begin
            sum_v[k] = TW'(a_a_reg[k]) + TW'(b_a_reg[k]);
            cnj_v[k] = (k < 3) ? -TW'(a_a_reg[k]) : TW'(a_a_reg[k]);
            mul_c[k] = clip_word(mul_v[k]);
            sum_c[k] = clip_word(sum_v[k]);
            cnj_c[k] = clip_word(cnj_v[k]);
            neg_b[k] = cnj_v[k][TW-1];
            mag_v[k] = neg_b[k] ? -cnj_v[k] : cnj_v[k];
            rem_b[k] = DW'(mag_v[k][W-1:0]) << (2 * F);
            norm_b   = norm_b + NW'(unsigned'(sq_a_reg[k]));
            zero_b   = zero_b && (a_a_reg[k] == '0);
        end

        res_b = '0;
        sat_b = 1'b0;
        unique case (act_a_reg)
            ACT_SUM: begin
                for (int k = 0; k < 4; k++) begin
                    res_b[k] = sum_c[k][W-1:0];
                    sat_b    = sat_b | sum_c[k][W];
                end
            end
            ACT_MUL: begin
                for (int k = 0; k < 4; k++) begin
                    res_b[k] = mul_c[k][W-1:0];
                    sat_b    = sat_b | mul_c[k][W];
                end
            end
            ACT_CONJ: begin
                for (int k = 0; k < 4; k++) begin
                    res_b[k] = cnj_c[k][W-1:0];
                    sat_b    = sat_b | cnj_c[k][W];
                end
            end
            default: begin
                // Inverse: the divider supplies the result.
                res_b = '0;
                sat_b = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            dv_rem_reg[0] <= rem_b;
            dv_q_reg[0]   <= '0;
            dv_ovf_reg[0] <= '0;
            dv_neg_reg[0] <= neg_b;
            dv_n_reg[0]   <= norm_b;
            dv_res_reg[0] <= res_b;
            dv_sat_reg[0] <= sat_b;
            dv_dz_reg[0]  <= (act_a_reg == ACT_INV) && zero_b;
            dv_inv_reg[0] <= (act_a_reg == ACT_INV) && !zero_b;
        end
    end

    // ------------------------------------------------------------------
    // Divider: the first step tests whether the quotient reaches 2^W
    // (certain saturation), each later step retires one quotient bit.
    // ------------------------------------------------------------------
    for (genvar j = 1; j <= NDIV; j++) begin : g_div
        // Quotient bit retired by this step; unused by the overflow step.
        localparam int QB = (j == 1) ? 0 : W + 1 - j;

        logic [3:0][DW-1:0] rem_nx;
        logic [3:0]         ge;
        logic [3:0][W-1:0]  q_nx;
        logic [3:0]         ovf_nx;

        qau_div_step #(
            .DW    (DW),
            .NW    (NW),
            .SHIFT (W + 1 - j)
        ) u_step (
            .norm    (dv_n_reg[j-1]),
            .rem_in  (dv_rem_reg[j-1]),
            .rem_out (rem_nx),
            .ge      (ge)
        );

        always_comb begin
            q_nx   = dv_q_reg[j-1];
            ovf_nx = dv_ovf_reg[j-1];
            for (int k = 0; k < 4; k++) begin
                if (j == 1) begin
                    ovf_nx[k] = ge[k];
                end else begin
                    q_nx[k][QB] = ge[k];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[j+1]) begin
                dv_rem_reg[j] <= rem_nx;
                dv_q_reg[j]   <= q_nx;
                dv_ovf_reg[j] <= ovf_nx;
                dv_neg_reg[j] <= dv_neg_reg[j-1];
                dv_n_reg[j]   <= dv_n_reg[j-1];
                dv_res_reg[j] <= dv_res_reg[j-1];
                dv_sat_reg[j] <= dv_sat_reg[j-1];
                dv_dz_reg[j]  <= dv_dz_reg[j-1];
                dv_inv_reg[j] <= dv_inv_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: clip the quotients, restore signs, merge the paths.
    // ------------------------------------------------------------------
    logic [3:0][W-1:0] out_data_reg;
    logic              out_sat_reg;
    logic              out_dz_reg;

    logic [3:0][W-1:0] fin_data;
    logic              fin_sat;
    logic [W-1:0]      lim;
    logic [W-1:0]      qv;

    always_comb begin
        fin_data = dv_res_reg[NDIV];
        fin_sat  = dv_sat_reg[NDIV];
        lim      = '0;
        qv       = '0;
        if (dv_dz_reg[NDIV]) begin
            fin_data = '0;
            fin_sat  = 1'b0;
        end else if (dv_inv_reg[NDIV]) begin
            fin_sat = 1'b0;
            for (int k = 0; k < 4; k++) begin
                lim = dv_neg_reg[NDIV][k] ? LIM_N : LIM_P;
                qv  = dv_q_reg[NDIV][k];
                if (dv_ovf_reg[NDIV][k] || (qv > lim)) begin
                    qv      = lim;
                    fin_sat = 1'b1;
                end
                fin_data[k] = dv_neg_reg[NDIV][k] ? -qv : qv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[NSTG-1]) begin
            out_data_reg <= fin_data;
            out_sat_reg  <= fin_sat;
            out_dz_reg   <= dv_dz_reg[NDIV];
        end
    end

    assign m_axis_tvalid          = vld_reg[NSTG-1];
    assign m_axis_tdata           = M_DW'(out_data_reg);
    assign m_axis_tuser[FLAG_SAT] = out_sat_reg;
    assign m_axis_tuser[FLAG_DZ]  = out_dz_reg;

endmodule

### rtl/qau_checker.sv
// Port-level checks for the quaternion arithmetic unit, bound to the top level.
module qau_checker
    import qau_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS,
    localparam int S_DW = ((8 * WORD_BITS + 7) / 8) * 8,
    localparam int M_DW = ((4 * WORD_BITS + 7) / 8) * 8
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [S_DW-1:0]   s_axis_tdata,
    input logic [ACT_W-1:0]  s_axis_tuser,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [M_DW-1:0]   m_axis_tdata,
    input logic [FLAG_W-1:0] m_axis_tuser
);

    // A held result word keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // An offered input word stays put until the unit takes it.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
        else $error("input word changed while stalled");

    // A zero-norm inverse reports an all-zero result without saturation.
    a_dz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[FLAG_DZ] |->
            (m_axis_tdata == '0) && !m_axis_tuser[FLAG_SAT])
        else $error("divide-by-zero result not clean");

    // The pipeline is empty right after reset.
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // With an empty output register every stage can move, so input is taken.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

endmodule

bind quaternion_arith_unit qau_checker #(
    .WORD_BITS (WORD_BITS)
) u_qau_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/quaternion_arith_unit_tb.sv
// Self-checking testbench for the quaternion arithmetic unit with a fixed-point predictor.
module quaternion_arith_unit_tb
    import qau_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = DEF_FRAC_BITS;
    localparam int WB = DEF_WORD_BITS;
    localparam int LATENCY = WB + 4;
    localparam int N_RANDOM = 600;
    localparam logic signed [15:0] QMAX = 16'sh7fff;
    localparam logic signed [15:0] QMIN = -16'sh8000;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } quat_t;

    typedef struct {
        quat_t q;
        logic  sat;
        logic  dz;
    } qresult_t;

    typedef struct {
        logic [ACT_W-1:0] act;
        quat_t            a;
        quat_t            b;
        logic             known;   // expected result typed into the table
        qresult_t         res;
    } qrow_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w from the lowest bit up
    logic [127:0]     s_axis_tdata = '0;
    // action
    logic [ACT_W-1:0] s_axis_tuser = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    // r_x, r_y, r_z, r_w from the lowest bit up
    logic [63:0]      m_axis_tdata;
    // saturated, div_by_zero from the lowest bit up
    logic [FLAG_W-1:0] m_axis_tuser;

    qresult_t pending_results[$];
    int       errors = 0;
    bit       stim_done = 1'b0;
    bit       hold_sink = 1'b0;   // sink held off for a long stretch

    quaternion_arith_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    // Clip a wide value to the signed word range, recording any clipping.
    function automatic logic signed [15:0] clip16(input longint v, inout logic sat);
        if (v > longint'(QMAX)) begin
            sat = 1'b1;
            return QMAX;
        end
        if (v < longint'(QMIN)) begin
            sat = 1'b1;
            return QMIN;
        end
        return v[15:0];
    endfunction

    // Raw product shifted right arithmetically: rounds toward minus infinity.
    function automatic longint fxmul(input logic signed [15:0] p, input logic signed [15:0] q);
        longint prod;
        prod = longint'(p) * longint'(q);
        return prod >>> FB;
    endfunction

    // c * 2^(2F) / n truncated toward zero; n fits easily in 34 bits here.
    function automatic longint fxdiv(input longint c, input longint n);
        longint mag;
        longint quo;
        mag = (c < 0) ? -c : c;
        quo = (mag <<< (2 * FB)) / n;
        return (c < 0) ? -quo : quo;
    endfunction

    function automatic qresult_t quat_alu(input logic [ACT_W-1:0] act,
                                          input quat_t a, input quat_t b);
        qresult_t r;
        longint   v[4];
        longint   norm;
        r.sat = 1'b0;
        r.dz  = 1'b0;
        v = '{0, 0, 0, 0};
        case (act)
            ACT_SUM: begin
                v[0] = a.x + b.x; v[1] = a.y + b.y;
                v[2] = a.z + b.z; v[3] = a.w + b.w;
            end
            ACT_MUL: begin
                v[0] = fxmul(a.w, b.x) + fxmul(a.x, b.w) + fxmul(a.y, b.z) - fxmul(a.z, b.y);
                v[1] = fxmul(a.w, b.y) + fxmul(a.y, b.w) - fxmul(a.x, b.z) + fxmul(a.z, b.x);
                v[2] = fxmul(a.w, b.z) + fxmul(a.z, b.w) + fxmul(a.x, b.y) - fxmul(a.y, b.x);
                v[3] = fxmul(a.w, b.w) - fxmul(a.x, b.x) - fxmul(a.y, b.y) - fxmul(a.z, b.z);
            end
            ACT_INV: begin
                norm = longint'(a.x) * a.x + longint'(a.y) * a.y
                     + longint'(a.z) * a.z + longint'(a.w) * a.w;
                if (norm == 0) begin
                    r.dz = 1'b1;
                end else begin
                    v[0] = fxdiv(-longint'(a.x), norm);
                    v[1] = fxdiv(-longint'(a.y), norm);
                    v[2] = fxdiv(-longint'(a.z), norm);
                    v[3] = fxdiv(longint'(a.w), norm);
                end
            end
            default: begin
                v[0] = -longint'(a.x); v[1] = -longint'(a.y);
                v[2] = -longint'(a.z); v[3] = a.w;
            end
        endcase
        r.q.x = clip16(v[0], r.sat);
        r.q.y = clip16(v[1], r.sat);
        r.q.z = clip16(v[2], r.sat);
        r.q.w = clip16(v[3], r.sat);
        return r;
    endfunction

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 9))
            0:       return QMAX;
            1:       return QMIN;
            2:       return 16'(int'($urandom_range(0, 8)) - 4);
            3, 4:    return 16'(int'($urandom_range(0, 8192)) - 4096);  // within +-1.0
            default: return 16'($urandom);
        endcase
    endfunction

    // Random gap: mostly none or short, now and then long.
    function automatic int rand_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic qrow_t row(input logic [ACT_W-1:0] act, input quat_t a, input quat_t b);
        qrow_t t;
        t.act = act;
        t.a = a;
        t.b = b;
        t.known = 1'b0;
        t.res = '{q: '0, sat: 1'b0, dz: 1'b0};
        return t;
    endfunction

    function automatic qrow_t row_exp(input logic [ACT_W-1:0] act, input quat_t a,
                                      input quat_t b, input quat_t rq,
                                      input logic sat, input logic dz);
        qrow_t t;
        t = row(act, a, b);
        t.known = 1'b1;
        t.res = '{q: rq, sat: sat, dz: dz};
        return t;
    endfunction

    // Offer one word at the falling edge and hold it until the unit takes it.
    // Valid stays high afterwards; idle_cycles drops it when a gap follows.
    task automatic send_word(input logic [ACT_W-1:0] act, input quat_t a, input quat_t b,
                             input qresult_t res);
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= act;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        pending_results.push_back(res);
        @(negedge aclk);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    // Sink: compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        qresult_t e;
        quat_t    got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_results.size() == 0) begin
                $error("unexpected result word %h", m_axis_tdata);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (got.x !== e.q.x) begin
                    $error("r_x exp %0d got %0d", e.q.x, got.x); errors++;
                end
                if (got.y !== e.q.y) begin
                    $error("r_y exp %0d got %0d", e.q.y, got.y); errors++;
                end
                if (got.z !== e.q.z) begin
                    $error("r_z exp %0d got %0d", e.q.z, got.z); errors++;
                end
                if (got.w !== e.q.w) begin
                    $error("r_w exp %0d got %0d", e.q.w, got.w); errors++;
                end
                if (m_axis_tuser[FLAG_SAT] !== e.sat) begin
                    $error("saturated exp %0b got %0b", e.sat, m_axis_tuser[FLAG_SAT]);
                    errors++;
                end
                if (m_axis_tuser[FLAG_DZ] !== e.dz) begin
                    $error("div_by_zero exp %0b got %0b", e.dz, m_axis_tuser[FLAG_DZ]);
                    errors++;
                end
            end
        end
    end

    // Receiver back-pressure, with one long hold-off on request.
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
                repeat (3 * LATENCY) @(negedge aclk);
                hold_sink = 1'b0;
            end
            gap = (stim_done || $urandom_range(0, 3) == 0) ? 0 : rand_gap();
            if (gap == 0) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    end

    initial begin
        qrow_t dir[$];
        quat_t zq, one, mx, mn, ra, rb;
        logic [ACT_W-1:0] act;
        qresult_t res;
        int wait_cnt;

        zq  = '0;
        one = '{w: 16'sd4096, z: 16'sd0, y: 16'sd0, x: 16'sd0};
        mx  = '{w: QMAX, z: QMAX, y: QMAX, x: QMAX};
        mn  = '{w: QMIN, z: QMIN, y: QMIN, x: QMIN};

        // Extremes, every operation and each special case.
        dir.push_back(row_exp(ACT_SUM, zq, zq, zq, 1'b0, 1'b0));
        dir.push_back(row_exp(ACT_SUM, mx, mx, mx, 1'b1, 1'b0));
        dir.push_back(row_exp(ACT_SUM, mn, mn, mn, 1'b1, 1'b0));
        dir.push_back(row_exp(ACT_SUM, mx, mn, '{w: -16'sd1, z: -16'sd1, y: -16'sd1,
                                                   x: -16'sd1}, 1'b0, 1'b0));
        dir.push_back(row_exp(ACT_MUL, one, one, one, 1'b0, 1'b0));
        dir.push_back(row(ACT_MUL, mx, mx));
        dir.push_back(row(ACT_MUL, mn, mn));
        dir.push_back(row(ACT_MUL, mx, mn));
        dir.push_back(row(ACT_MUL, '{w: -16'sd1, z: 16'sd3, y: -16'sd2, x: 16'sd1},
                          '{w: 16'sd1, z: -16'sd1, y: 16'sd5, x: -16'sd7}));
        // Zero norm: all-zero result with the divide flag, b does not matter.
        dir.push_back(row_exp(ACT_INV, zq, mx, zq, 1'b0, 1'b1));
        dir.push_back(row_exp(ACT_INV, one, mn, one, 1'b0, 1'b0));
        dir.push_back(row(ACT_INV, mx, zq));
        dir.push_back(row(ACT_INV, mn, zq));
        dir.push_back(row(ACT_INV, '{w: 16'sd1, z: 16'sd0, y: 16'sd0, x: 16'sd0}, zq));
        dir.push_back(row(ACT_INV, '{w: 16'sd0, z: 16'sd0, y: 16'sd0, x: -16'sd1}, zq));
        dir.push_back(row(ACT_INV, '{w: 16'sd2048, z: -16'sd2048, y: 16'sd2048,
                                     x: -16'sd2048}, mx));
        dir.push_back(row_exp(ACT_CONJ, zq, mx, zq, 1'b0, 1'b0));
        // Negating the minimum clips to the largest positive word.
        dir.push_back(row_exp(ACT_CONJ, mn, zq, '{w: QMIN, z: QMAX, y: QMAX, x: QMAX},
                              1'b1, 1'b0));
        dir.push_back(row_exp(ACT_CONJ, mx, mn, '{w: QMAX, z: -QMAX, y: -QMAX, x: -QMAX},
                              1'b0, 1'b0));

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir[i]) begin
            res = dir[i].known ? dir[i].res : quat_alu(dir[i].act, dir[i].a, dir[i].b);
            send_word(dir[i].act, dir[i].a, dir[i].b, res);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            // Long receiver stall while words keep coming, so the pipe fills up.
            if (n == 150) hold_sink = 1'b1;
            // Sender pause until the unit has drained completely.
            if (n == 350) begin
                idle_cycles(1);
                wait_cnt = 0;
                while (pending_results.size() != 0 && wait_cnt < 100000) begin
                    @(negedge aclk);
                    wait_cnt++;
                end
            end
            act = ACT_W'($urandom_range(0, 3));
            ra = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
            rb = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
            if (act == ACT_INV && $urandom_range(0, 19) == 0) ra = zq;
            send_word(act, ra, rb, quat_alu(act, ra, rb));
            if (!(n >= 150 && n < 150 + 4 * LATENCY) && $urandom_range(0, 2) == 0)
                idle_cycles(rand_gap());
        end

        idle_cycles(1);
        stim_done = 1'b1;
        wait_cnt = 0;
        while (pending_results.size() != 0 && wait_cnt < 100000) begin
            @(negedge aclk);
            wait_cnt++;
        end
        repeat (2 * LATENCY) @(negedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### files.f
rtl/qau_pkg.sv
rtl/qau_div_step.sv
rtl/quaternion_arith_unit.sv
rtl/qau_checker.sv
tb/quaternion_arith_unit_tb.sv
